FILE: design/serial_flash_programmer_engine_defines.svh
// Assertion macros for the serial flash programmer engine.
`ifndef SERIAL_FLASH_PROGRAMMER_ENGINE_DEFINES_SVH
`define SERIAL_FLASH_PROGRAMMER_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SFPE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFPE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/sfpe_pkg.sv
// Constants, types and reply tables of the serial flash programmer engine.
package sfpe_pkg;

   localparam int OP_DEPTH   = 4096;
   localparam int ADDR_BITS  = 18;
   localparam int ENTRY_LEN  = 5;
   localparam int OP_ENTRIES = OP_DEPTH / ENTRY_LEN;
   localparam int OP_IDX_W   = $clog2(OP_ENTRIES);
   localparam int OP_CNT_W   = $clog2(OP_ENTRIES + 1);
   localparam int OP_ENTRY_W = 1 + ADDR_BITS + 8;
   localparam int MEM_DEPTH  = 1 << ADDR_BITS;

   localparam logic [7:0] B_ACK = 8'h06;
   localparam logic [7:0] B_NAK = 8'h15;

   // Host command bytes
   localparam logic [7:0] CMD_NOP      = 8'h00;
   localparam logic [7:0] CMD_IFACE    = 8'h01;
   localparam logic [7:0] CMD_CMDMAP   = 8'h02;
   localparam logic [7:0] CMD_NAME     = 8'h03;
   localparam logic [7:0] CMD_SERBUF   = 8'h04;
   localparam logic [7:0] CMD_BUSTYPE  = 8'h05;
   localparam logic [7:0] CMD_CHIPSIZE = 8'h06;
   localparam logic [7:0] CMD_OPBUF    = 8'h07;
   localparam logic [7:0] CMD_WRNMAX   = 8'h08;
   localparam logic [7:0] CMD_READ1    = 8'h09;
   localparam logic [7:0] CMD_READN    = 8'h0A;
   localparam logic [7:0] CMD_OPINIT   = 8'h0B;
   localparam logic [7:0] CMD_OPWRITE  = 8'h0C;
   localparam logic [7:0] CMD_OPWRN    = 8'h0D;
   localparam logic [7:0] CMD_OPDELAY  = 8'h0E;
   localparam logic [7:0] CMD_EXEC     = 8'h0F;
   localparam logic [7:0] CMD_SYNC     = 8'h10;
   localparam logic [7:0] CMD_RDNMAX   = 8'h11;
   localparam logic [7:0] CMD_SETBUS   = 8'h12;

   // Pending reply kinds
   localparam logic [4:0] K_NONE     = 5'd0;
   localparam logic [4:0] K_ACK      = 5'd1;
   localparam logic [4:0] K_NAK      = 5'd2;
   localparam logic [4:0] K_IFACE    = 5'd3;
   localparam logic [4:0] K_CMDMAP   = 5'd4;
   localparam logic [4:0] K_NAME     = 5'd5;
   localparam logic [4:0] K_SERBUF   = 5'd6;
   localparam logic [4:0] K_BUSTYPE  = 5'd7;
   localparam logic [4:0] K_CHIPSIZE = 5'd8;
   localparam logic [4:0] K_OPBUF    = 5'd9;
   localparam logic [4:0] K_WRNMAX   = 5'd10;
   localparam logic [4:0] K_SYNC     = 5'd11;
   localparam logic [4:0] K_RDNMAX   = 5'd12;
   localparam logic [4:0] K_STREAM   = 5'd13;

   // Argument phase of the parser
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_READ1 = 3'd1;
   localparam logic [2:0] PH_READN = 3'd2;
   localparam logic [2:0] PH_WRITE = 3'd3;
   localparam logic [2:0] PH_DELAY = 3'd4;

   localparam logic [7:0] NAME_BYTES [16] = '{
      8'h48, 8'h38, 8'h2F, 8'h33, 8'h30, 8'h34, 8'h38, 8'h46,
      8'h2D, 8'h53, 8'h45, 8'h52, 8'h50, 8'h52, 8'h4F, 8'h47};

   typedef struct packed {
      logic                  en;
      logic [OP_IDX_W-1:0]   addr;
      logic [OP_ENTRY_W-1:0] data;
   } op_wr_type;

   typedef struct packed {
      logic                en;
      logic [OP_IDX_W-1:0] addr;
   } op_rd_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
      logic [7:0]           data;
   } tgt_wr_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
   } tgt_rd_type;

   function automatic logic [5:0] fixed_len(input logic [4:0] kind);
      logic [5:0] n;
      n = 6'd0;
      case (kind)
         K_ACK, K_NAK:                  n = 6'd1;
         K_IFACE, K_SERBUF, K_OPBUF:    n = 6'd3;
         K_CMDMAP:                      n = 6'd33;
         K_NAME:                        n = 6'd17;
         K_BUSTYPE, K_CHIPSIZE, K_SYNC: n = 6'd2;
         K_WRNMAX, K_RDNMAX:            n = 6'd4;
         default:                       n = 6'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] fixed_byte(input logic [4:0] kind, input logic [5:0] idx);
      logic [7:0] b;
      logic [5:0] pos;
      b   = 8'h00;
      pos = idx - 6'd1;
      if (idx == 6'd0) begin
         b = (kind == K_NAK || kind == K_SYNC) ? B_NAK : B_ACK;
      end else begin
         case (kind)
            K_IFACE:    if (idx == 6'd1) b = 8'h01;
            K_CMDMAP:   if (idx == 6'd1) b = 8'hFF;
                        else if (idx == 6'd2) b = 8'hDF;
                        else if (idx == 6'd3) b = 8'h03;
            K_NAME:     if (idx <= 6'd16) b = NAME_BYTES[pos[3:0]];
            K_SERBUF:   if (idx == 6'd1) b = 8'h80;
            K_BUSTYPE:  if (idx == 6'd1) b = 8'h01;
            K_CHIPSIZE: if (idx == 6'd1) b = 8'(ADDR_BITS);
            K_OPBUF:    if (idx == 6'd1) b = 8'(OP_DEPTH % 256);
                        else if (idx == 6'd2) b = 8'((OP_DEPTH / 256) % 256);
            K_WRNMAX:   if (idx == 6'd1) b = 8'h01;
            K_SYNC:     if (idx == 6'd1) b = B_ACK;
            default:    b = 8'h00;
         endcase
      end
      return b;
   endfunction

endpackage

FILE: design/serial_flash_programmer_engine.sv
// Top level of the serial flash programmer engine: parser, sequencer, reply path.
`include "serial_flash_programmer_engine_defines.svh"
// Usage:
//  req channel: one item per host event. req_tuser = 0 carries a received host
//  byte in req_tdata; req_tuser = 1 pulls the next reply byte.
//  rsp channel: one item per pull. rsp_tuser is 1 when a reply byte is given,
//  rsp_tdata is the byte, rsp_tlast marks the final byte of a reply.
//  A pull's item is registered in the cycle after the pull is accepted, but a
//  byte of a read command goes through ST_READ first, as it waits on the
//  registered read port of the target memory.
//  Execute walks the operation buffer one entry per cycle, through the single
//  read port of the buffer memory.
//  After reset the target memory is filled with 0xFF, one byte per cycle;
//  req_tready stays low until the fill is done.
//  A finished item waits in the output register while rsp_tready is low;
//  host bytes are still taken then, a further pull waits until it drains.
module serial_flash_programmer_engine (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   input  logic       req_tuser,   // [0] mode
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] tx_byte
   output logic       rsp_tuser,   // [0] tx_valid
   output logic       rsp_tlast    // reply_last
);
   import sfpe_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_EXEC  = 4'b0100,
      ST_READ  = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [ADDR_BITS-1:0]  clr_addr_ff, clr_addr_in;
   logic [2:0]            phase_ff, phase_in;
   logic [2:0]            arg_cnt_ff, arg_cnt_in;
   logic [23:0]           addr_ff, addr_in;
   logic [23:0]           len_ff, len_in;
   logic [OP_CNT_W-1:0]   fill_ff, fill_in;
   logic [OP_CNT_W-1:0]   exec_idx_ff, exec_idx_in;
   logic                  exec_pend_ff, exec_pend_in;
   logic [4:0]            kind_ff, kind_in;
   logic [5:0]            idx_ff, idx_in;
   logic [23:0]           remain_ff, remain_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_user_ff, rsp_user_in;
   logic [7:0]            rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   op_wr_type             op_wr;
   op_rd_type             op_rd;
   logic [OP_ENTRY_W-1:0] op_rd_data;
   tgt_wr_type            tgt_wr;
   tgt_rd_type            tgt_rd;
   logic [7:0]            tgt_rd_data;

   logic                  accept;
   logic [23:0]           arg_addr, arg_len;
   logic [2:0]            arg_need, arg_next;
   logic [5:0]            fix_next;
   logic [23:0]           rem_dec;

   sfpe_op_buf u_op_buf (
      .clock   (clock),
      .wr      (op_wr),
      .rd      (op_rd),
      .rd_data (op_rd_data)
   );

   sfpe_tgt_mem u_tgt_mem (
      .clock   (clock),
      .wr      (tgt_wr),
      .rd      (tgt_rd),
      .rd_data (tgt_rd_data)
   );

   // Pulls wait for a free output register; host bytes never produce an item.
   assign req_tready = (state_ff == ST_IDLE) && (!req_tuser || !rsp_valid_ff);
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Argument byte merged into the little-endian registers.
   always_comb begin
      arg_addr = addr_ff;
      arg_len  = len_ff;
      case (arg_cnt_ff)
         3'd0:    arg_addr[7:0]   = req_tdata;
         3'd1:    arg_addr[15:8]  = req_tdata;
         3'd2:    arg_addr[23:16] = req_tdata;
         3'd3:    arg_len[7:0]    = req_tdata;
         3'd4:    arg_len[15:8]   = req_tdata;
         3'd5:    arg_len[23:16]  = req_tdata;
         default: arg_addr = addr_ff;
      endcase
      arg_next = arg_cnt_ff + 3'd1;
      arg_need = (phase_ff == PH_READN) ? 3'd6 : ((phase_ff == PH_READ1) ? 3'd3 : 3'd4);
   end

   assign fix_next = idx_ff + 6'd1;
   assign rem_dec  = (remain_ff != 24'd0) ? (remain_ff - 24'd1) : remain_ff;

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      phase_in     = phase_ff;
      arg_cnt_in   = arg_cnt_ff;
      addr_in      = addr_ff;
      len_in       = len_ff;
      fill_in      = fill_ff;
      exec_idx_in  = exec_idx_ff;
      exec_pend_in = 1'b0;
      kind_in      = kind_ff;
      idx_in       = idx_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_user_in  = rsp_user_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      op_wr        = '0;
      op_rd        = '0;
      tgt_wr       = '0;
      tgt_rd       = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            tgt_wr.en   = 1'b1;
            tgt_wr.addr = clr_addr_ff;
            tgt_wr.data = 8'hFF;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (&clr_addr_ff) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept && !req_tuser) begin
               if (phase_ff == PH_IDLE) begin
                  kind_in = K_NONE;   // a new command drops any unsent reply
                  idx_in  = 6'd0;
                  unique case (req_tdata)
                     CMD_NOP:      kind_in = K_ACK;
                     CMD_IFACE:    kind_in = K_IFACE;
                     CMD_CMDMAP:   kind_in = K_CMDMAP;
                     CMD_NAME:     kind_in = K_NAME;
                     CMD_SERBUF:   kind_in = K_SERBUF;
                     CMD_BUSTYPE:  kind_in = K_BUSTYPE;
                     CMD_CHIPSIZE: kind_in = K_CHIPSIZE;
                     CMD_OPBUF:    kind_in = K_OPBUF;
                     CMD_WRNMAX:   kind_in = K_WRNMAX;
                     CMD_READ1, CMD_READN, CMD_OPWRITE, CMD_OPDELAY: begin
                        phase_in   = (req_tdata == CMD_READ1) ? PH_READ1 :
                                     (req_tdata == CMD_READN) ? PH_READN :
                                     (req_tdata == CMD_OPWRITE) ? PH_WRITE : PH_DELAY;
                        arg_cnt_in = 3'd0;
                        addr_in    = 24'd0;
                        len_in     = 24'd0;
                     end
                     CMD_OPINIT: begin
                        fill_in = '0;
                        kind_in = K_ACK;
                     end
                     CMD_OPWRN, CMD_SETBUS: kind_in = K_NAK;
                     CMD_EXEC: begin
                        exec_idx_in = '0;
                        state_in    = ST_EXEC;
                     end
                     CMD_SYNC:     kind_in = K_SYNC;
                     CMD_RDNMAX:   kind_in = K_RDNMAX;
                     default:      kind_in = K_NONE;   // unknown byte: no answer
                  endcase
               end else begin
                  addr_in    = arg_addr;
                  len_in     = arg_len;
                  arg_cnt_in = arg_next;
                  if (arg_next >= arg_need) begin
                     phase_in   = PH_IDLE;
                     arg_cnt_in = 3'd0;
                     idx_in     = 6'd0;
                     if (phase_ff == PH_READ1) begin
                        remain_in = 24'd1;
                        kind_in   = K_STREAM;
                     end else if (phase_ff == PH_READN) begin
                        remain_in = arg_len;
                        kind_in   = K_STREAM;
                     end else if (fill_ff == OP_CNT_W'(OP_ENTRIES)) begin
                        kind_in = K_NAK;   // entry does not fit
                     end else begin
                        op_wr.en   = 1'b1;
                        op_wr.addr = fill_ff[OP_IDX_W-1:0];
                        op_wr.data = {phase_ff == PH_WRITE, arg_addr[ADDR_BITS-1:0],
                                      arg_len[7:0]};
                        fill_in    = fill_ff + 1'b1;
                        kind_in    = K_ACK;
                     end
                  end
               end
            end else if (accept) begin
               rsp_valid_in = 1'b1;
               if (kind_ff == K_STREAM) begin
                  if (idx_ff == 6'd0) begin
                     rsp_user_in = 1'b1;
                     rsp_data_in = B_ACK;
                     rsp_last_in = (remain_ff == 24'd0);
                     idx_in      = 6'd1;
                     if (remain_ff == 24'd0) begin
                        kind_in = K_NONE;
                        idx_in  = 6'd0;
                     end
                  end else begin
                     // memory byte: result leaves from ST_READ
                     rsp_valid_in = 1'b0;
                     tgt_rd.en    = 1'b1;
                     tgt_rd.addr  = addr_ff[ADDR_BITS-1:0];
                     state_in     = ST_READ;
                  end
               end else if (kind_ff == K_NONE || kind_ff > K_STREAM) begin
                  rsp_user_in = 1'b0;
                  rsp_data_in = 8'h00;
                  rsp_last_in = 1'b0;
               end else begin
                  rsp_user_in = 1'b1;
                  rsp_data_in = fixed_byte(kind_ff, idx_ff);
                  rsp_last_in = (fix_next >= fixed_len(kind_ff));
                  idx_in      = fix_next;
                  if (fix_next >= fixed_len(kind_ff)) begin
                     kind_in = K_NONE;
                     idx_in  = 6'd0;
                  end
               end
            end
         end

         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_user_in  = 1'b1;
            rsp_data_in  = tgt_rd_data;
            rsp_last_in  = (rem_dec == 24'd0);
            addr_in      = addr_ff + 24'd1;
            remain_in    = rem_dec;
            if (rem_dec == 24'd0) begin
               kind_in = K_NONE;
               idx_in  = 6'd0;
            end
            state_in = ST_IDLE;
         end

         ST_EXEC: begin
            // read entry k while entry k-1 is applied
            if (exec_idx_ff < fill_ff) begin
               op_rd.en     = 1'b1;
               op_rd.addr   = exec_idx_ff[OP_IDX_W-1:0];
               exec_idx_in  = exec_idx_ff + 1'b1;
               exec_pend_in = 1'b1;
            end
            if (exec_pend_ff && op_rd_data[OP_ENTRY_W-1]) begin
               tgt_wr.en   = 1'b1;
               tgt_wr.addr = op_rd_data[ADDR_BITS+7:8];
               tgt_wr.data = op_rd_data[7:0];
            end
            if (!(exec_idx_ff < fill_ff) && !exec_pend_ff) begin
               fill_in  = '0;
               kind_in  = K_ACK;
               idx_in   = 6'd0;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         phase_ff     <= PH_IDLE;
         arg_cnt_ff   <= 3'd0;
         addr_ff      <= 24'd0;
         len_ff       <= 24'd0;
         fill_ff      <= '0;
         exec_idx_ff  <= '0;
         exec_pend_ff <= 1'b0;
         kind_ff      <= K_NONE;
         idx_ff       <= 6'd0;
         remain_ff    <= 24'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         phase_ff     <= phase_in;
         arg_cnt_ff   <= arg_cnt_in;
         addr_ff      <= addr_in;
         len_ff       <= len_in;
         fill_ff      <= fill_in;
         exec_idx_ff  <= exec_idx_in;
         exec_pend_ff <= exec_pend_in;
         kind_ff      <= kind_in;
         idx_ff       <= idx_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   `SFPE_ASSERT_NEXT(a_read_gives_item, state_ff == ST_READ, rsp_valid_ff,
      "memory read did not produce an item")
   `SFPE_ASSERT_NOW(a_fill_bound, 1'b1, fill_ff <= OP_CNT_W'(OP_ENTRIES),
      "operation buffer overfilled")
   `SFPE_ASSERT_NEXT(a_pull_answers,
      accept && req_tuser && !(kind_ff == K_STREAM && idx_ff != 6'd0), rsp_valid_ff,
      "pull accepted without an item")
   `SFPE_ASSERT_NOW(a_exec_no_accept, state_ff == ST_EXEC, !accept,
      "item accepted during execute")

endmodule

FILE: design/sfpe_op_buf.sv
// Operation buffer memory: one queued write or delay entry per word.
module sfpe_op_buf (
   input  logic                          clock,
   input  sfpe_pkg::op_wr_type           wr,
   input  sfpe_pkg::op_rd_type           rd,
   output logic [sfpe_pkg::OP_ENTRY_W-1:0] rd_data
);
   import sfpe_pkg::*;

   logic [OP_ENTRY_W-1:0] mem [OP_ENTRIES];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data <= mem[rd.addr];
      end
   end

endmodule

FILE: design/sfpe_tgt_mem.sv
// Target memory array written by executed entries and read by read commands.
module sfpe_tgt_mem (
   input  logic                 clock,
   input  sfpe_pkg::tgt_wr_type wr,
   input  sfpe_pkg::tgt_rd_type rd,
   output logic [7:0]           rd_data
);
   import sfpe_pkg::*;

   logic [7:0] mem [MEM_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data <= mem[rd.addr];
      end
   end

endmodule
